// ----- hw/rtl/cocos_pkg.sv -----
// cocos_pkg: shared types and constants for the two-row sketch update core
// covers the input and result word layouts and the modulo unit handshake
// no dependencies
`timescale 1ns / 1ps

package cocos_pkg;

    localparam int KEY_W   = 64;
    localparam int HASH_W  = 32;
    localparam int RAND_W  = 32;
    localparam int CNT_W   = 8;
    localparam int ROW_IDX_W = 16;

    // saturation value of a bucket count
    localparam logic [CNT_W-1:0] COUNT_MAX = 8'hff;

    // register index decoded from the config address
    localparam logic REG_THRESHOLD = 1'b0;

    // one input word
    typedef struct packed {
        logic [KEY_W-1:0]  flow_key;
        logic [HASH_W-1:0] key_hash;
        logic [RAND_W-1:0] random_word;
    } item_t;

    // one result word
    typedef struct packed {
        logic [KEY_W-1:0]     reported_key;
        logic [ROW_IDX_W-1:0] row0_index;
        logic [ROW_IDX_W-1:0] row1_index;
        logic [CNT_W-1:0]     reported_count;
    } result_t;

    // request to the shared modulo unit
    typedef struct packed {
        logic              start;
        logic [RAND_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
    } mod_req_t;

    // response from the shared modulo unit
    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] remainder;
    } mod_rsp_t;

endpackage

// ----- hw/rtl/cocos_ram.sv -----
// cocos_ram: generic single write port, single read port RAM
// read data is registered; no reset on the array or read data
// no dependencies
`timescale 1ns / 1ps

module cocos_ram #(
    parameter int WIDTH     = 72,
    parameter int ADDR_BITS = 16
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    localparam int DEPTH = 2 ** ADDR_BITS;

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hw/rtl/cocos_mod_unit.sv -----
// cocos_mod_unit: iterative 32-by-8 remainder, one dividend bit per cycle
// restoring shift-subtract, one step per dividend bit, done pulses for one cycle
// depends on cocos_pkg
`timescale 1ns / 1ps

module cocos_mod_unit
    import cocos_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mod_req_t req,
    output mod_rsp_t rsp
);

    localparam int STEP_W = $clog2(RAND_W);

    logic              active_reg, active_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [RAND_W-1:0] dvd_reg, dvd_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W:0]    shifted;
    logic [CNT_W:0]    diff;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        shifted = {rem_reg, dvd_reg[RAND_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
    end

    // step sequencing
    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        step_next   = step_reg;
        dvd_next    = dvd_reg;
        dvs_next    = dvs_reg;
        rem_next    = rem_reg;
        if (req.start)
        begin
            active_next = 1'b1;
            step_next   = '0;
            dvd_next    = req.dividend;
            dvs_next    = req.divisor;
            rem_next    = '0;
        end
        else if (active_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = diff[CNT_W-1:0];
            end
            else
            begin
                rem_next = shifted[CNT_W-1:0];
            end
            dvd_next  = {dvd_reg[RAND_W-2:0], 1'b0};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(RAND_W - 1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            step_reg   <= step_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ----- hw/rtl/two_row_coco_sketch_update_core.sv -----
// a word whose key hits a row passes S_READ, S_EVAL and S_WRITE, then the result strobe is registered
// a word that misses both rows also waits in S_MOD for the remainder unit before S_WRITE
// busy stays high until the word is written back, so no new word is taken before then
// the strobe is raised only if the new count exceeds the threshold; each row RAM has one read port
// after reset a clearing pass zeroes all 2**INDEX_BITS entries of both rows, with busy high
// the receiver cannot stall: each result is shown for exactly one cycle
`timescale 1ns / 1ps

module two_row_coco_sketch_update_core
    import cocos_pkg::*;
#(
    parameter int INDEX_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // command side
    input  logic        start,
    input  item_t       item,
    output logic        busy,
    // result side
    output logic        result_strobe,
    output result_t     result,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ROW_W = KEY_W + CNT_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_MOD   = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [INDEX_BITS-1:0] clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]      thr_reg, thr_next;
    logic                  strobe_reg, strobe_next;
    result_t               result_reg, result_next;

    logic [KEY_W-1:0]      key_reg, key_next;
    logic [RAND_W-1:0]     rnd_reg, rnd_next;
    logic [INDEX_BITS-1:0] idx0_reg, idx0_next;
    logic [INDEX_BITS-1:0] idx1_reg, idx1_next;
    logic                  sel1_reg, sel1_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [KEY_W-1:0]      bkey_reg, bkey_next;

    logic [ROW_W-1:0]      row0_rd, row1_rd;
    logic [ROW_W-1:0]      wr_data;
    logic [INDEX_BITS-1:0] wr_addr0, wr_addr1;
    logic                  wr_en0, wr_en1;
    logic                  hit0, hit1, take1;
    logic [CNT_W-1:0]      cnt_old, cnt_bumped;
    logic                  accept;
    logic                  cfg_write;
    mod_req_t              mod_req;
    mod_rsp_t              mod_rsp;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;

    // bucket decision from the row read data
    always_comb
    begin
        hit0  = (row0_rd[ROW_W-1:CNT_W] == key_reg);
        hit1  = (row1_rd[ROW_W-1:CNT_W] == key_reg);
        take1 = !hit0 && (hit1 || (row0_rd[CNT_W-1:0] > row1_rd[CNT_W-1:0]));
        cnt_old    = take1 ? row1_rd[CNT_W-1:0] : row0_rd[CNT_W-1:0];
        cnt_bumped = (cnt_old == COUNT_MAX) ? COUNT_MAX : cnt_old + CNT_W'(1);
    end

    // remainder request on a miss
    always_comb
    begin
        mod_req.start    = (state_reg == S_EVAL) && !hit0 && !hit1;
        mod_req.dividend = rnd_reg;
        mod_req.divisor  = cnt_bumped;
    end

    cocos_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    // row write ports: clearing pass or bucket write-back
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            wr_data  = '0;
            wr_addr0 = clr_addr_reg;
            wr_addr1 = clr_addr_reg;
            wr_en0   = 1'b1;
            wr_en1   = 1'b1;
        end
        else
        begin
            wr_data  = {bkey_reg, (cnt_reg > thr_reg) ? CNT_W'(0) : cnt_reg};
            wr_addr0 = idx0_reg;
            wr_addr1 = idx1_reg;
            wr_en0   = (state_reg == S_WRITE) && !sel1_reg;
            wr_en1   = (state_reg == S_WRITE) && sel1_reg;
        end
    end

    cocos_ram #(
        .WIDTH     (ROW_W),
        .ADDR_BITS (INDEX_BITS)
    ) u_row0 (
        .clk     (clk),
        .wr_en   (wr_en0),
        .wr_addr (wr_addr0),
        .wr_data (wr_data),
        .rd_addr (idx0_reg),
        .rd_data (row0_rd)
    );

    cocos_ram #(
        .WIDTH     (ROW_W),
        .ADDR_BITS (INDEX_BITS)
    ) u_row1 (
        .clk     (clk),
        .wr_en   (wr_en1),
        .wr_addr (wr_addr1),
        .wr_data (wr_data),
        .rd_addr (idx1_reg),
        .rd_data (row1_rd)
    );

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        strobe_next   = 1'b0;
        result_next   = result_reg;
        key_next      = key_reg;
        rnd_next      = rnd_reg;
        idx0_next     = idx0_reg;
        idx1_next     = idx1_reg;
        sel1_next     = sel1_reg;
        cnt_next      = cnt_reg;
        bkey_next     = bkey_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + INDEX_BITS'(1);
                if (clr_addr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next   = item.flow_key;
                    rnd_next   = item.random_word;
                    idx0_next  = item.key_hash[ROW_IDX_W +: INDEX_BITS];
                    idx1_next  = item.key_hash[INDEX_BITS-1:0];
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                sel1_next = take1;
                cnt_next  = cnt_bumped;
                if (hit0 || hit1)
                begin
                    bkey_next  = key_reg;
                    state_next = S_WRITE;
                end
                else
                begin
                    bkey_next  = take1 ? row1_rd[ROW_W-1:CNT_W] : row0_rd[ROW_W-1:CNT_W];
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_rsp.done)
                begin
                    if (mod_rsp.remainder == '0)
                    begin
                        bkey_next = key_reg;
                    end
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                strobe_next                = (cnt_reg > thr_reg);
                result_next.reported_key   = bkey_reg;
                result_next.row0_index     = ROW_IDX_W'(idx0_reg);
                result_next.row1_index     = ROW_IDX_W'(idx1_reg);
                result_next.reported_count = cnt_reg;
                state_next                 = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // threshold register write
    always_comb
    begin
        thr_next = thr_reg;
        if (cfg_write && (paddr[2] == REG_THRESHOLD))
        begin
            thr_next = pwdata[CNT_W-1:0];
        end
    end

    // config read path
    assign prdata = (paddr[2] == REG_THRESHOLD) ? {24'd0, thr_reg} : 32'd0;
    assign pready = 1'b1;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            thr_reg      <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            thr_reg      <= thr_next;
            strobe_reg   <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        key_reg    <= key_next;
        rnd_reg    <= rnd_next;
        idx0_reg   <= idx0_next;
        idx1_reg   <= idx1_next;
        sel1_reg   <= sel1_next;
        cnt_reg    <= cnt_next;
        bkey_reg   <= bkey_next;
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

endmodule

// ----- hw/rtl/cocos_checker.sv -----
// cocos_checker: port-level assertions for the sketch update core
// attached to two_row_coco_sketch_update_core by the bind at the end of this file
// depends on cocos_pkg
`timescale 1ns / 1ps

module cocos_checker
    import cocos_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    result_strobe,
    input result_t result
);

    // an accepted word keeps the core busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("core not busy after accepting a word");

    // results never come back to back
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |=> !result_strobe)
        else $error("result strobe held for more than one cycle");

    // a result only follows a busy cycle
    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result word without preceding work");

    // a reported count is never zero
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (result.reported_count != '0))
        else $error("reported count is zero");

endmodule

bind two_row_coco_sketch_update_core cocos_checker u_cocos_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_strobe (result_strobe),
    .result        (result)
);
